@@ src/hill_cipher_2x2_macros.svh @@
// Assertion helpers shared by the cipher RTL.
// Each macro expands to one labeled concurrent assertion on clk_i with
// the active-low reset masking the check.
`ifndef HILL_CIPHER_2X2_MACROS_SVH
`define HILL_CIPHER_2X2_MACROS_SVH

// Same-cycle implication.
`define HC2_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HC2_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/hc2_pkg.sv @@
`default_nettype none

package hc2_pkg;

  // Letter arithmetic
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned SUM_W    = 10;
  localparam logic [LETTER_W-1:0] MODULUS    = 5'd26;
  localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

  // floor(x / 26) == (x * RECIP_26) >> RECIP_SHIFT for every x below 651
  localparam logic [11:0] RECIP_26    = 12'd2521;
  localparam int unsigned RECIP_SHIFT = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R0C1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_R1C1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_RED,
    ST_DONE
  } hc2_state_e;

  // Micro-steps of one pair; encrypt runs the first four, decrypt all eight unless the key has no inverse
  typedef enum logic [2:0] {
    STEP_0,
    STEP_1,
    STEP_2,
    STEP_3,
    STEP_4,
    STEP_5,
    STEP_6,
    STEP_7
  } hc2_step_e;

  // Controls of the shared multiply-accumulate unit
  typedef struct packed {
    logic mul;  // capture base + a*b
    logic red;  // reduce captured sum mod 26 into the accumulator
    logic clr;  // base is zero instead of the accumulator
  } hc2_mac_ctl_t;

  // Fold a 5-bit value into 0..25
  function automatic logic [LETTER_W-1:0] hc2_red5(input logic [LETTER_W-1:0] x);
    return (x >= MODULUS) ? (x - MODULUS) : x;
  endfunction

  // Inverse of d mod 26 for d in 0..25, zero when d shares a factor with 26
  function automatic logic [LETTER_W-1:0] hc2_det_inv(input logic [LETTER_W-1:0] d);
    logic [LETTER_W-1:0] r;
    case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/hc2_mac.sv @@
`default_nettype none

module hc2_mac (
  input  wire logic                              clk_i,
  input  wire hc2_pkg::hc2_mac_ctl_t             ctl_i,
  input  wire logic [hc2_pkg::LETTER_W-1:0]      op_a_i,
  input  wire logic [hc2_pkg::LETTER_W-1:0]      op_b_i,
  output logic      [hc2_pkg::LETTER_W-1:0]      acc_o
);

  logic [hc2_pkg::LETTER_W-1:0] a_red;
  logic [hc2_pkg::LETTER_W-1:0] b_red;
  logic [hc2_pkg::SUM_W-1:0]    prod;
  logic [hc2_pkg::SUM_W-1:0]    base;
  logic [hc2_pkg::SUM_W-1:0]    sum_d;
  logic [hc2_pkg::SUM_W-1:0]    sum_q;
  logic [21:0]                  scaled;
  logic [hc2_pkg::LETTER_W-1:0] quot;
  logic [hc2_pkg::SUM_W-1:0]    quot_x26;
  logic [hc2_pkg::SUM_W-1:0]    rem;
  logic [hc2_pkg::LETTER_W-1:0] acc_q;

  // Multiply phase: fold operands, multiply, add base
  assign a_red = hc2_pkg::hc2_red5(op_a_i);
  assign b_red = hc2_pkg::hc2_red5(op_b_i);
  assign prod  = {5'b0, a_red} * {5'b0, b_red};
  assign base  = ctl_i.clr ? '0 : {5'b0, acc_q};
  assign sum_d = base + prod;

  // Reduce phase: quotient by reciprocal, remainder is exact
  assign scaled   = {12'b0, sum_q} * {10'b0, hc2_pkg::RECIP_26};
  assign quot     = scaled[hc2_pkg::RECIP_SHIFT +: hc2_pkg::LETTER_W];
  assign quot_x26 = {5'b0, quot} * {5'b0, hc2_pkg::MODULUS};
  assign rem      = sum_q - quot_x26;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      sum_q <= sum_d;
    end
    if (ctl_i.red) begin
      acc_q <= rem[hc2_pkg::LETTER_W-1:0];
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

@@ src/hill_cipher_2x2.sv @@
// First letter of a pair: stored in a holding register, no result.
// Each multiply-accumulate step of the shared unit has two phases (multiply, reduce).
// The input stalls while a pair is computed and until the two-entry result buffer drains.
// Reset clears the key to zero, selects encrypt and drops any half pair.
`default_nettype none
`include "hill_cipher_2x2_macros.svh"

module hill_cipher_2x2 (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // configuration
  input  wire logic                               cfg_we_i,
  input  wire logic [hc2_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [hc2_pkg::LETTER_W-1:0]       cfg_wdata_i,
  // input letters
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [hc2_pkg::LETTER_W-1:0]       letter_in_i,
  input  wire logic                               message_last_i,
  // output letters
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [hc2_pkg::LETTER_W-1:0]       letter_out_o,
  output logic                                    pair_last_o,
  output logic                                    message_end_o,
  output logic                                    key_error_o
);

  localparam int unsigned LW = hc2_pkg::LETTER_W;

  hc2_pkg::hc2_state_e   state_q, state_d;
  hc2_pkg::hc2_step_e    step_q, step_d;
  hc2_pkg::hc2_step_e    last_step;
  hc2_pkg::hc2_mac_ctl_t mac_ctl;

  logic [LW-1:0] key00_q, key01_q, key10_q, key11_q;
  logic          dec_q;
  logic [LW-1:0] held_q, held_d;
  logic          half_q, half_d;
  logic [LW-1:0] p0_q, p0_d, p1_q, p1_d;
  logic          end_q, end_d;
  logic          err_q, err_d;
  logic [LW-1:0] inv_q, inv_d;
  logic [LW-1:0] res0_q, res0_d;
  logic [LW-1:0] op_a, op_b;
  logic [LW-1:0] acc;
  logic [LW-1:0] neg01, neg10;
  logic [LW-1:0] det_inv;

  logic [1:0]    ob_cnt_q, ob_cnt_d;
  logic [LW-1:0] ob_l0_q, ob_l1_q;
  logic          ob_end_q, ob_err_q;
  logic          ob_load;
  logic          accept, pop, ob_first;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key00_q <= '0;
      key01_q <= '0;
      key10_q <= '0;
      key11_q <= '0;
      dec_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hc2_pkg::REG_KEY_R0C0:     key00_q <= cfg_wdata_i;
        hc2_pkg::REG_KEY_R0C1:     key01_q <= cfg_wdata_i;
        hc2_pkg::REG_KEY_R1C0:     key10_q <= cfg_wdata_i;
        hc2_pkg::REG_KEY_R1C1:     key11_q <= cfg_wdata_i;
        hc2_pkg::REG_DECRYPT_MODE: dec_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Shared multiply-accumulate unit
  hc2_mac u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .acc_o  (acc)
  );

  assign neg01   = hc2_pkg::MODULUS - hc2_pkg::hc2_red5(key01_q);
  assign neg10   = hc2_pkg::MODULUS - hc2_pkg::hc2_red5(key10_q);
  assign det_inv = hc2_pkg::hc2_det_inv(acc);
  assign last_step = dec_q ? hc2_pkg::STEP_7 : hc2_pkg::STEP_3;

  // Operand select per micro-step
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    mac_ctl = '0;
    if (dec_q) begin
      case (step_q)
        hc2_pkg::STEP_0: begin op_a = key00_q; op_b = key11_q; mac_ctl.clr = 1'b1; end
        hc2_pkg::STEP_1: begin op_a = neg01;   op_b = key10_q; end
        hc2_pkg::STEP_2: begin op_a = p0_q;    op_b = key11_q; mac_ctl.clr = 1'b1; end
        hc2_pkg::STEP_3: begin op_a = p1_q;    op_b = neg10;   end
        hc2_pkg::STEP_4: begin op_a = acc;     op_b = inv_q;   mac_ctl.clr = 1'b1; end
        hc2_pkg::STEP_5: begin op_a = p0_q;    op_b = neg01;   mac_ctl.clr = 1'b1; end
        hc2_pkg::STEP_6: begin op_a = p1_q;    op_b = key00_q; end
        hc2_pkg::STEP_7: begin op_a = acc;     op_b = inv_q;   mac_ctl.clr = 1'b1; end
        default: ;
      endcase
    end else begin
      case (step_q)
        hc2_pkg::STEP_0: begin op_a = p0_q; op_b = key00_q; mac_ctl.clr = 1'b1; end
        hc2_pkg::STEP_1: begin op_a = p1_q; op_b = key10_q; end
        hc2_pkg::STEP_2: begin op_a = p0_q; op_b = key01_q; mac_ctl.clr = 1'b1; end
        hc2_pkg::STEP_3: begin op_a = p1_q; op_b = key11_q; end
        default: ;
      endcase
    end
    mac_ctl.mul = (state_q == hc2_pkg::ST_MUL);
    mac_ctl.red = (state_q == hc2_pkg::ST_RED);
  end

  assign in_stall_o = (state_q != hc2_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;

  // Sequencer: pairing, micro-steps, hand-off to the result buffer
  always_comb begin
    state_d  = state_q;
    step_d   = step_q;
    held_d   = held_q;
    half_d   = half_q;
    p0_d     = p0_q;
    p1_d     = p1_q;
    end_d    = end_q;
    err_d    = err_q;
    inv_d    = inv_q;
    res0_d   = res0_q;
    ob_load  = 1'b0;
    ob_cnt_d = ob_cnt_q - {1'b0, pop};
    case (state_q)
      hc2_pkg::ST_IDLE: begin
        if (accept) begin
          if (half_q) begin
            p0_d    = held_q;
            p1_d    = letter_in_i;
            end_d   = message_last_i;
            half_d  = 1'b0;
            held_d  = '0;
            err_d   = 1'b0;
            step_d  = hc2_pkg::STEP_0;
            state_d = hc2_pkg::ST_MUL;
          end else if (message_last_i) begin
            half_d = 1'b0;
            held_d = '0;
            // odd final letter: pad when encrypting, drop when decrypting
            if (!dec_q) begin
              p0_d    = letter_in_i;
              p1_d    = hc2_pkg::PAD_LETTER;
              end_d   = 1'b1;
              err_d   = 1'b0;
              step_d  = hc2_pkg::STEP_0;
              state_d = hc2_pkg::ST_MUL;
            end
          end else begin
            held_d = letter_in_i;
            half_d = 1'b1;
          end
        end
      end
      hc2_pkg::ST_MUL: begin
        state_d = hc2_pkg::ST_RED;
        // first result letter is final once the second column starts
        if ((dec_q && step_q == hc2_pkg::STEP_5) || (!dec_q && step_q == hc2_pkg::STEP_2)) begin
          res0_d = acc;
        end
        // determinant is ready: look up its inverse, bail out if none
        if (dec_q && step_q == hc2_pkg::STEP_2) begin
          inv_d = det_inv;
          if (det_inv == '0) begin
            err_d   = 1'b1;
            state_d = hc2_pkg::ST_DONE;
          end
        end
      end
      hc2_pkg::ST_RED: begin
        if (step_q == last_step) begin
          state_d = hc2_pkg::ST_DONE;
        end else begin
          step_d  = hc2_pkg::hc2_step_e'(step_q + 3'd1);
          state_d = hc2_pkg::ST_MUL;
        end
      end
      hc2_pkg::ST_DONE: begin
        // wait until the result buffer is empty, then load both letters
        if (ob_cnt_q == 2'd0) begin
          ob_load  = 1'b1;
          ob_cnt_d = 2'd2;
          state_d  = hc2_pkg::ST_IDLE;
        end
      end
      default: state_d = hc2_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= hc2_pkg::ST_IDLE;
      step_q   <= hc2_pkg::STEP_0;
      half_q   <= 1'b0;
      held_q   <= '0;
      ob_cnt_q <= 2'd0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      half_q   <= half_d;
      held_q   <= held_d;
      ob_cnt_q <= ob_cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    end_q  <= end_d;
    err_q  <= err_d;
    inv_q  <= inv_d;
    res0_q <= res0_d;
    if (ob_load) begin
      ob_l0_q  <= err_q ? '0 : res0_q;
      ob_l1_q  <= err_q ? '0 : acc;
      ob_end_q <= end_q;
      ob_err_q <= err_q;
    end
  end

  // Result buffer: two beats, first letter then second
  assign ob_first      = (ob_cnt_q == 2'd2);
  assign out_valid_o   = (ob_cnt_q != 2'd0);
  assign letter_out_o  = ob_first ? ob_l0_q : ob_l1_q;
  assign pair_last_o   = !ob_first;
  assign message_end_o = !ob_first && ob_end_q;
  assign key_error_o   = ob_err_q;

  `HC2_ASSERT_NXT(a_red_next, state_q == hc2_pkg::ST_RED,
    state_q == hc2_pkg::ST_MUL || state_q == hc2_pkg::ST_DONE, "reduce step went astray")
  `HC2_ASSERT_NXT(a_done_load, state_q == hc2_pkg::ST_DONE && ob_cnt_q == 2'd0,
    ob_cnt_q == 2'd2 && state_q == hc2_pkg::ST_IDLE, "pair not handed to result buffer")
  `HC2_ASSERT_IMP(a_err_zero, out_valid_o && key_error_o,
    letter_out_o == '0, "bad key beat carries a nonzero letter")
  `HC2_ASSERT_IMP(a_enc_steps, state_q != hc2_pkg::ST_IDLE && !dec_q,
    step_q <= hc2_pkg::STEP_3, "encrypt ran past its last step")

endmodule

`default_nettype wire
